### rtl/ccp_pkg.sv
// Shared types, widths and the push saturation helper for the capsule/circle push-out block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ccp_pkg;

    localparam int CW       = 24;            // coordinate width, Q15.8
    localparam int DW       = 16;            // direction width, Q1.14
    localparam int DIR_FRAC = 14;
    localparam int RW       = CW - 1;        // radius / length width
    localparam int RRW      = CW;            // summed radius width
    localparam int VW       = CW + 1;        // coordinate difference width
    localparam int PW       = VW + DW;       // one projection product
    localparam int LQW      = PW + 1;        // projection sum
    localparam int DEPW     = RRW + DIR_FRAC; // normal depth, Q.22
    localparam int D2W      = 2 * VW;        // squared distance
    localparam int ROOTW    = D2W / 2;       // integer square root
    localparam int SQRW     = ROOTW + 3;     // root remainder working width
    localparam int MMW      = DW + DEPW;     // normal push product
    localparam int NSHIFT   = 2 * DIR_FRAC;
    localparam int MQW      = MMW + 1 - NSHIFT; // rounded normal push magnitude
    localparam int DMW      = VW + RRW;      // radial push dividend
    localparam int DQW      = CW;            // radial quotient bits
    localparam int DRW      = DMW - DQW;     // divisor / remainder width
    localparam int SQ_STAGES = ROOTW;
    localparam int DV_STAGES = DQW;
    localparam int CFG_IW   = 3;

    typedef enum logic [CFG_IW-1:0] {
        CFG_START_X, CFG_START_Y, CFG_END_X, CFG_END_Y,
        CFG_DIR_X, CFG_DIR_Y, CFG_LENGTH, CFG_RADIUS
    } t_cfg_idx;

    typedef struct packed {
        logic [CW-1:0] start_x;
        logic [CW-1:0] start_y;
        logic [CW-1:0] end_x;
        logic [CW-1:0] end_y;
        logic [DW-1:0] dir_x;
        logic [DW-1:0] dir_y;
        logic [RW-1:0] len;
        logic [RW-1:0] rad;
    } t_cfg;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic            is_end;
        logic            sgn_x;
        logic            sgn_y;
        logic [VW-1:0]   ux;
        logic [VW-1:0]   uy;
        logic [RRW-1:0]  r;
        logic            mid_ov;
        logic            mid_negx;
        logic            mid_negy;
        logic [DW-1:0]   magx;
        logic [DW-1:0]   magy;
        logic [DEPW-1:0] depth;
    } t_job;

    // clamp a magnitude with sign into the signed coordinate range
    function automatic logic [CW-1:0] sat_push(input logic [MQW-1:0] mag, input logic neg);
        logic [MQW-1:0] lim;
        lim = MQW'(1) << (CW - 1);
        if (neg) begin
            if (mag >= lim) return {1'b1, {(CW-1){1'b0}}};
            return CW'(-mag);
        end
        if (mag >= lim) return {1'b0, {(CW-1){1'b1}}};
        return CW'(mag);
    endfunction

endpackage

### rtl/ccp_front.sv
// Front end: input capture, projection onto the capsule axis and region classification.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccp_pkg::t_cfg         i_cfg,
    input  logic                  i_acc,
    input  logic [ccp_pkg::CW-1:0] i_circle_x,
    input  logic [ccp_pkg::CW-1:0] i_circle_y,
    input  logic [ccp_pkg::RW-1:0] i_circle_radius,
    input  logic                  i_stall,
    output logic                  o_push,
    output ccp_pkg::t_job         o_job
);
    import ccp_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic [CW-1:0] r_cx1, r_cy1, r_cx2, r_cy2, r_cx3, r_cy3;
    logic [RRW-1:0] r_r1, r_r2, r_r3;
    logic signed [VW-1:0] r_tx, r_ty;
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [LQW-1:0] r_lq, r_s;
    t_job r_job, n_job;

    logic              lt, gt;
    logic [CW-1:0]     ex, ey;
    logic signed [VW-1:0] vx, vy;
    logic [LQW-1:0]    ms;
    logic [DEPW-1:0]   rq;

    always_comb begin
        lt = r_lq[LQW-1];
        gt = r_lq > $signed({{(LQW-RW-DIR_FRAC){1'b0}}, i_cfg.len, {DIR_FRAC{1'b0}}});
        ex = lt ? i_cfg.start_x : i_cfg.end_x;
        ey = lt ? i_cfg.start_y : i_cfg.end_y;
        vx = VW'($signed(r_cx3)) - VW'($signed(ex));
        vy = VW'($signed(r_cy3)) - VW'($signed(ey));
        ms = r_s[LQW-1] ? LQW'(-r_s) : LQW'(r_s);
        rq = {r_r3, {DIR_FRAC{1'b0}}};
        n_job.is_end   = lt | gt;
        n_job.sgn_x    = vx[VW-1];
        n_job.sgn_y    = vy[VW-1];
        n_job.ux       = vx[VW-1] ? VW'(-vx) : VW'(vx);
        n_job.uy       = vy[VW-1] ? VW'(-vy) : VW'(vy);
        n_job.r        = r_r3;
        n_job.mid_ov   = ms < LQW'(rq);
        n_job.depth    = rq - ms[DEPW-1:0];
        // px follows -dir_y, py follows dir_x; a negative side flips both
        n_job.magx     = i_cfg.dir_y[DW-1] ? DW'(-i_cfg.dir_y) : i_cfg.dir_y;
        n_job.magy     = i_cfg.dir_x[DW-1] ? DW'(-i_cfg.dir_x) : i_cfg.dir_x;
        n_job.mid_negx = (!i_cfg.dir_y[DW-1] && (i_cfg.dir_y != '0)) ^ r_s[LQW-1];
        n_job.mid_negy = i_cfg.dir_x[DW-1] ^ r_s[LQW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (!i_stall) begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_cx1 <= i_circle_x;
            r_cy1 <= i_circle_y;
            r_tx  <= VW'($signed(i_circle_x)) - VW'($signed(i_cfg.start_x));
            r_ty  <= VW'($signed(i_circle_y)) - VW'($signed(i_cfg.start_y));
            r_r1  <= RRW'(i_circle_radius) + RRW'(i_cfg.rad);

            r_cx2 <= r_cx1;
            r_cy2 <= r_cy1;
            r_r2  <= r_r1;
            r_p1  <= PW'(r_tx) * PW'($signed(i_cfg.dir_x));
            r_p2  <= PW'(r_ty) * PW'($signed(i_cfg.dir_y));
            r_p3  <= PW'(r_ty) * PW'($signed(i_cfg.dir_x));
            r_p4  <= PW'(r_tx) * PW'($signed(i_cfg.dir_y));

            r_cx3 <= r_cx2;
            r_cy3 <= r_cy2;
            r_r3  <= r_r2;
            r_lq  <= LQW'(r_p1) + LQW'(r_p2);
            r_s   <= LQW'(r_p3) - LQW'(r_p4);

            r_job <= n_job;
        end
    end

    assign o_push = r_v4 & ~i_stall;
    assign o_job  = r_job;

endmodule

### rtl/ccp_queue.sv
// Two-word queue between front and back end; the back end drains one word a cycle.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccp_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output ccp_pkg::t_job o_job
);
    import ccp_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop = r_cnt != 2'd0;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) n_cnt = r_cnt + 2'd1;
        if (!i_push && pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = pop;
    assign o_job   = r_mem[r_rp];

endmodule

### rtl/ccp_sqrt.sv
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on ccp_pkg.
`timescale 1ns / 1ps

module ccp_sqrt (
    input  logic                     i_clk,
    input  logic [ccp_pkg::D2W-1:0]  i_x,
    output logic [ccp_pkg::ROOTW-1:0] o_root
);
    import ccp_pkg::*;

    logic [SQRW-1:0]  r_rem  [0:SQ_STAGES-1];
    logic [ROOTW-1:0] r_root [0:SQ_STAGES-1];
    logic [D2W-1:0]   r_x    [0:SQ_STAGES-1];

    for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
        logic [SQRW-1:0]  s_rem, cur, trial;
        logic [ROOTW-1:0] s_root;
        logic [D2W-1:0]   s_x;
        if (i == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_x    = i_x;
        end else begin : g_next
            assign s_rem  = r_rem[i-1];
            assign s_root = r_root[i-1];
            assign s_x    = r_x[i-1];
        end
        // bring down two bits, try (root << 2) | 1
        assign cur   = {s_rem[SQRW-3:0], s_x[D2W-1:D2W-2]};
        assign trial = {1'b0, s_root, 2'b01};
        always_ff @(posedge i_clk) begin
            if (cur >= trial) begin
                r_rem[i]  <= cur - trial;
                r_root[i] <= {s_root[ROOTW-2:0], 1'b1};
            end else begin
                r_rem[i]  <= cur;
                r_root[i] <= {s_root[ROOTW-2:0], 1'b0};
            end
            r_x[i] <= {s_x[D2W-3:0], 2'b00};
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

### rtl/ccp_div.sv
// Pipelined restoring divider for the radial push, one quotient bit per stage.
// Depends on ccp_pkg. Flags quotients that do not fit the coordinate width.
`timescale 1ns / 1ps

module ccp_div (
    input  logic                    i_clk,
    input  logic [ccp_pkg::DMW-1:0] i_m,
    input  logic [ccp_pkg::DRW-1:0] i_d,
    output logic [ccp_pkg::DQW-1:0] o_q,
    output logic [ccp_pkg::DRW-1:0] o_rem,
    output logic [ccp_pkg::DRW-1:0] o_d,
    output logic                    o_ovf
);
    import ccp_pkg::*;

    logic [DRW-1:0] r_rem [0:DV_STAGES-1];
    logic [DQW-1:0] r_q   [0:DV_STAGES-1];
    logic [DQW-1:0] r_m   [0:DV_STAGES-1];
    logic [DRW-1:0] r_d   [0:DV_STAGES-1];
    logic           r_ovf [0:DV_STAGES-1];

    for (genvar i = 0; i < DV_STAGES; i++) begin : g_stage
        logic [DRW-1:0] s_rem, s_d;
        logic [DQW-1:0] s_q, s_m;
        logic           s_ovf;
        logic [DRW:0]   cur;
        if (i == 0) begin : g_first
            assign s_rem = i_m[DMW-1:DQW];
            assign s_q   = '0;
            assign s_m   = i_m[DQW-1:0];
            assign s_d   = i_d;
            assign s_ovf = i_m[DMW-1:DQW] >= i_d;
        end else begin : g_next
            assign s_rem = r_rem[i-1];
            assign s_q   = r_q[i-1];
            assign s_m   = r_m[i-1];
            assign s_d   = r_d[i-1];
            assign s_ovf = r_ovf[i-1];
        end
        assign cur = {s_rem, s_m[DQW-1]};
        always_ff @(posedge i_clk) begin
            if (cur >= {1'b0, s_d}) begin
                r_rem[i] <= DRW'(cur - {1'b0, s_d});
                r_q[i]   <= {s_q[DQW-2:0], 1'b1};
            end else begin
                r_rem[i] <= DRW'(cur);
                r_q[i]   <= {s_q[DQW-2:0], 1'b0};
            end
            r_m[i]   <= {s_m[DQW-2:0], 1'b0};
            r_d[i]   <= s_d;
            r_ovf[i] <= s_ovf;
        end
    end

    assign o_q   = r_q[DV_STAGES-1];
    assign o_rem = r_rem[DV_STAGES-1];
    assign o_d   = r_d[DV_STAGES-1];
    assign o_ovf = r_ovf[DV_STAGES-1];

endmodule

### rtl/ccp_back.sv
// Back end: squared distance, square root, radial divide, normal push and result select.
// Depends on ccp_pkg, ccp_sqrt and ccp_div.
`timescale 1ns / 1ps

module ccp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  ccp_pkg::t_job          i_job,
    output logic                   o_valid,
    output logic                   o_overlap,
    output logic [ccp_pkg::CW-1:0] o_push_x,
    output logic [ccp_pkg::CW-1:0] o_push_y
);
    import ccp_pkg::*;

    typedef struct packed {
        logic             is_end;
        logic             ov_end;
        logic             d2_zero;
        logic             sgn_x;
        logic             sgn_y;
        logic [VW-1:0]    ux;
        logic [VW-1:0]    uy;
        logic [RRW-1:0]   r;
        logic             mid_ov;
        logic             mid_negx;
        logic             mid_negy;
        logic [MQW-1:0]   qmx;
        logic [MQW-1:0]   qmy;
    } t_side;

    // stage 1: products
    logic             r_v1;
    t_job             r_j1;
    logic [D2W-1:0]   r_sqx, r_sqy;
    logic [2*RRW-1:0] r_rr1;
    logic [MMW-1:0]   r_mx, r_my;
    // stage 2: sums
    logic             r_v2;
    t_side            r_s2, n_sa;
    logic [D2W-1:0]   r_d2;
    logic [2*RRW-1:0] r_rr2;
    // delay lines beside the root and divide pipes
    logic             r_va [0:SQ_STAGES-1];
    logic             r_vb [0:DV_STAGES-1];
    logic             r_v4;
    t_side            r_la [0:SQ_STAGES-1];
    t_side            r_lb [0:DV_STAGES-1];
    t_side            r_s4;
    logic [ROOTW-1:0] root, r_dist;
    logic [RRW-1:0]   k;
    logic [DMW-1:0]   r_mx2, r_my2;
    // divider outputs
    logic [DQW-1:0]   qx, qy;
    logic [DRW-1:0]   remx, remy, dvx, dvy;
    logic             ovfx, ovfy;
    t_side            s6;
    logic [MQW-1:0]   magx, magy;
    logic             ov;
    logic [CW-1:0]    n_px, n_py;
    logic             r_ov;
    logic             r_vo;
    logic [CW-1:0]    r_px, r_py;

    always_ff @(posedge i_clk) begin
        r_j1  <= i_job;
        r_sqx <= D2W'(i_job.ux) * D2W'(i_job.ux);
        r_sqy <= D2W'(i_job.uy) * D2W'(i_job.uy);
        r_rr1 <= (2*RRW)'(i_job.r) * (2*RRW)'(i_job.r);
        r_mx  <= MMW'(i_job.magx) * MMW'(i_job.depth);
        r_my  <= MMW'(i_job.magy) * MMW'(i_job.depth);

        r_d2  <= r_sqx + r_sqy;
        r_rr2 <= r_rr1;
        r_s2.is_end   <= r_j1.is_end;
        r_s2.ov_end   <= 1'b0;
        r_s2.d2_zero  <= 1'b0;
        r_s2.sgn_x    <= r_j1.sgn_x;
        r_s2.sgn_y    <= r_j1.sgn_y;
        r_s2.ux       <= r_j1.ux;
        r_s2.uy       <= r_j1.uy;
        r_s2.r        <= r_j1.r;
        r_s2.mid_ov   <= r_j1.mid_ov;
        r_s2.mid_negx <= r_j1.mid_negx;
        r_s2.mid_negy <= r_j1.mid_negy;
        // round the Q.36 product to Q.8, half away from zero on the magnitude
        r_s2.qmx <= MQW'(((MMW+1)'(r_mx) + ((MMW+1)'(1) << (NSHIFT-1))) >> NSHIFT);
        r_s2.qmy <= MQW'(((MMW+1)'(r_my) + ((MMW+1)'(1) << (NSHIFT-1))) >> NSHIFT);
    end

    always_comb begin
        n_sa         = r_s2;
        n_sa.ov_end  = r_d2 < D2W'(r_rr2);
        n_sa.d2_zero = r_d2 == '0;
    end

    ccp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_x    (r_d2),
        .o_root (root)
    );

    // k is only used when the circle overlaps, and then root < r
    assign k = RRW'((ROOTW+1)'(r_la[SQ_STAGES-1].r) - (ROOTW+1)'(root));

    always_ff @(posedge i_clk) begin
        r_dist <= root;
        r_mx2  <= DMW'(r_la[SQ_STAGES-1].ux) * DMW'(k);
        r_my2  <= DMW'(r_la[SQ_STAGES-1].uy) * DMW'(k);
    end

    ccp_div u_div_x (
        .i_clk (i_clk),
        .i_m   (r_mx2),
        .i_d   (r_dist),
        .o_q   (qx),
        .o_rem (remx),
        .o_d   (dvx),
        .o_ovf (ovfx)
    );

    ccp_div u_div_y (
        .i_clk (i_clk),
        .i_m   (r_my2),
        .i_d   (r_dist),
        .o_q   (qy),
        .o_rem (remy),
        .o_d   (dvy),
        .o_ovf (ovfy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v4 <= 1'b0;
            for (int i = 0; i < SQ_STAGES; i++) r_va[i] <= 1'b0;
            for (int i = 0; i < DV_STAGES; i++) r_vb[i] <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_va[0] <= r_v2;
            for (int i = 1; i < SQ_STAGES; i++) r_va[i] <= r_va[i-1];
            r_v4    <= r_va[SQ_STAGES-1];
            r_vb[0] <= r_v4;
            for (int i = 1; i < DV_STAGES; i++) r_vb[i] <= r_vb[i-1];
            r_vo    <= r_vb[DV_STAGES-1];
        end
    end

    // payload of the side lines, no reset
    always_ff @(posedge i_clk) begin
        r_la[0] <= n_sa;
        for (int i = 1; i < SQ_STAGES; i++)
            r_la[i] <= r_la[i-1];
        r_s4 <= r_la[SQ_STAGES-1];
        r_lb[0] <= r_s4;
        for (int i = 1; i < DV_STAGES; i++)
            r_lb[i] <= r_lb[i-1];
    end

    always_comb begin
        s6 = r_lb[DV_STAGES-1];
        // round to nearest, ties away: bump when 2*rem >= divisor
        magx = ovfx ? '1 : MQW'(qx) + MQW'({remx, 1'b0} >= {1'b0, dvx});
        magy = ovfy ? '1 : MQW'(qy) + MQW'({remy, 1'b0} >= {1'b0, dvy});
        ov   = s6.is_end ? s6.ov_end : s6.mid_ov;
        n_px = '0;
        n_py = '0;
        if (s6.is_end) begin
            if (s6.ov_end && !s6.d2_zero) begin
                n_px = sat_push(magx, s6.sgn_x);
                n_py = sat_push(magy, s6.sgn_y);
            end
        end else if (s6.mid_ov) begin
            n_px = sat_push(s6.qmx, s6.mid_negx);
            n_py = sat_push(s6.qmy, s6.mid_negy);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ov <= ov;
        r_px <= n_px;
        r_py <= n_py;
    end

    assign o_valid   = r_vo;
    assign o_overlap = r_ov;
    assign o_push_x  = r_px;
    assign o_push_y  = r_py;

endmodule

### rtl/capsule_circle_pushout.sv
// Circle against 2D capsule: overlap flag and push-out vector, Q15.8 coordinates.
// A new circle may be started on every clock while busy is low; each result is shown on o_valid
// for one cycle, in the order of the starts. Each result passes through the 25-stage square root
// and the 24-stage radial divider in the back end; results cannot be held off, so take each one
// in the cycle it is shown.
// Write configuration only with no query in flight.
// Depends on ccp_pkg, ccp_front, ccp_queue and ccp_back.
`timescale 1ns / 1ps

module capsule_circle_pushout (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ccp_pkg::CW-1:0] i_circle_x,
    input  logic [ccp_pkg::CW-1:0] i_circle_y,
    input  logic [ccp_pkg::RW-1:0] i_circle_radius,
    input  logic                   i_cfg_we,
    input  logic [ccp_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [ccp_pkg::CW-1:0] i_cfg_data,
    output logic                   o_valid,
    output logic                   o_overlap,
    output logic [ccp_pkg::CW-1:0] o_push_x,
    output logic [ccp_pkg::CW-1:0] o_push_y
);
    import ccp_pkg::*;

    t_cfg r_cfg;
    logic q_full, q_valid, f_push;
    t_job f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= '0;
            r_cfg.dir_x   <= DW'(1) << DIR_FRAC;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_X: r_cfg.start_x <= i_cfg_data;
                CFG_START_Y: r_cfg.start_y <= i_cfg_data;
                CFG_END_X:   r_cfg.end_x   <= i_cfg_data;
                CFG_END_Y:   r_cfg.end_y   <= i_cfg_data;
                CFG_DIR_X:   r_cfg.dir_x   <= i_cfg_data[DW-1:0];
                CFG_DIR_Y:   r_cfg.dir_y   <= i_cfg_data[DW-1:0];
                CFG_LENGTH:  r_cfg.len     <= i_cfg_data[RW-1:0];
                CFG_RADIUS:  r_cfg.rad     <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    assign busy = q_full;

    ccp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_acc           (start & ~busy),
        .i_circle_x      (i_circle_x),
        .i_circle_y      (i_circle_y),
        .i_circle_radius (i_circle_radius),
        .i_stall         (q_full),
        .o_push          (f_push),
        .o_job           (f_job)
    );

    ccp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ccp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_job     (q_job),
        .o_valid   (o_valid),
        .o_overlap (o_overlap),
        .o_push_x  (o_push_x),
        .o_push_y  (o_push_y)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for capsule_circle_pushout: random and directed circle queries
// against several capsule settings, each result checked against an in-bench push-out predictor.
// Depends on ccp_pkg and the capsule_circle_pushout RTL.
`timescale 1ns / 1ps

module testbench;
    import ccp_pkg::*;

    typedef struct packed {
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [RW-1:0] cr;
    } t_circle;

    typedef struct packed {
        logic          ov;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
    } t_push;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [CW-1:0] i_circle_x = '0;
    logic [CW-1:0] i_circle_y = '0;
    logic [RW-1:0] i_circle_radius = '0;
    logic          i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CW-1:0] i_cfg_data = '0;
    logic          o_valid;
    logic          o_overlap;
    logic [CW-1:0] o_push_x;
    logic [CW-1:0] o_push_y;

    capsule_circle_pushout i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_circle_x(i_circle_x), .i_circle_y(i_circle_y), .i_circle_radius(i_circle_radius),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_overlap(o_overlap), .o_push_x(o_push_x), .o_push_y(o_push_y)
    );

    always #2 i_clk = ~i_clk;

    t_circle circle_q[$];
    t_push   push_q[$];
    int      fails = 0;
    int      idle_pct = 0;
    bit      took = 1'b0;
    t_cfg    caps;

    function automatic longint sat_coord(longint v);
        longint hi;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint radial_push(longint v, longint unsigned k, longint unsigned dv);
        longint unsigned m, q, rm;
        m = (v < 0 ? -v : v) * k;
        q = m / dv;
        rm = m % dv;
        if (rm >= dv - rm) q++;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return sat_coord(v < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint normal_push(longint c, longint unsigned depth, bit neg);
        longint unsigned m, q;
        m = (c < 0 ? -c : c) * depth;
        q = (m + (64'd1 << 27)) >> 28;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return sat_coord(((c < 0) != neg) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_push predict_push(t_circle c);
        longint cx, cy, sx, sy, dx, dy, tx, ty, lq, lenq, ex, ey, vx, vy, s;
        longint unsigned r, d2, droot, ms, rq;
        t_push res;
        cx = longint'(signed'(c.cx));
        cy = longint'(signed'(c.cy));
        sx = longint'(signed'(caps.start_x));
        sy = longint'(signed'(caps.start_y));
        dx = longint'(signed'(caps.dir_x));
        dy = longint'(signed'(caps.dir_y));
        tx = cx - sx;
        ty = cy - sy;
        lq = tx * dx + ty * dy;
        lenq = longint'(caps.len) <<< 14;
        r = longint'(c.cr) + longint'(caps.rad);
        res = '0;
        if (lq < 0 || lq > lenq) begin
            ex = lq < 0 ? sx : longint'(signed'(caps.end_x));
            ey = lq < 0 ? sy : longint'(signed'(caps.end_y));
            vx = cx - ex;
            vy = cy - ey;
            d2 = vx * vx + vy * vy;
            res.ov = d2 < r * r;
            if (res.ov && d2 != 0) begin
                droot = int_sqrt(d2);
                res.px = CW'(radial_push(vx, r - droot, droot));
                res.py = CW'(radial_push(vy, r - droot, droot));
            end
        end else begin
            s = ty * dx - tx * dy;
            ms = s < 0 ? -s : s;
            rq = r << 14;
            res.ov = ms < rq;
            if (res.ov) begin
                res.px = CW'(normal_push(-dy, rq - ms, s < 0));
                res.py = CW'(normal_push(dx, rq - ms, s < 0));
            end
        end
        return res;
    endfunction

    // driver: one word per accepted start, idling at random
    always @(negedge i_clk) begin
        if (took) void'(circle_q.pop_front());
        if (i_rst_n && circle_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            i_circle_x <= circle_q[0].cx;
            i_circle_y <= circle_q[0].cy;
            i_circle_radius <= circle_q[0].cr;
        end else begin
            start <= 1'b0;
        end
    end

    // predict at acceptance, check each strobed word
    always @(posedge i_clk) begin
        t_push got, exp_push;
        took = i_rst_n && start && !busy;
        if (took)
            push_q.push_back(predict_push({i_circle_x, i_circle_y, i_circle_radius}));
        if (i_rst_n && o_valid) begin
            got = {o_overlap, o_push_x, o_push_y};
            if (push_q.size() == 0) begin
                $error("result with nothing expected");
                fails++;
            end else begin
                exp_push = push_q.pop_front();
                if (got.ov !== exp_push.ov) begin
                    $error("overlap exp %0d got %0d", exp_push.ov, got.ov); fails++;
                end
                if (got.px !== exp_push.px) begin
                    $error("push_x exp %0h got %0h", exp_push.px, got.px); fails++;
                end
                if (got.py !== exp_push.py) begin
                    $error("push_y exp %0h got %0h", exp_push.py, got.py); fails++;
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CW-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_X: caps.start_x = val;
            CFG_START_Y: caps.start_y = val;
            CFG_END_X:   caps.end_x = val;
            CFG_END_Y:   caps.end_y = val;
            CFG_DIR_X:   caps.dir_x = val[DW-1:0];
            CFG_DIR_Y:   caps.dir_y = val[DW-1:0];
            CFG_LENGTH:  caps.len = val[RW-1:0];
            default:     caps.rad = val[RW-1:0];
        endcase
    endtask

    // set a capsule along (ux,uy) unit direction in Q1.14 with given length and radius
    task automatic set_capsule(int sx, int sy, int ux, int uy, int len, int rad);
        write_reg(CFG_START_X, CW'(sx));
        write_reg(CFG_START_Y, CW'(sy));
        write_reg(CFG_END_X, CW'(sx + ((longint'(ux) * len) >>> 14)));
        write_reg(CFG_END_Y, CW'(sy + ((longint'(uy) * len) >>> 14)));
        write_reg(CFG_DIR_X, CW'(ux));
        write_reg(CFG_DIR_Y, CW'(uy));
        write_reg(CFG_LENGTH, CW'(len));
        write_reg(CFG_RADIUS, CW'(rad));
    endtask

    task automatic add_circle(int x, int y, int r);
        circle_q.push_back({CW'(x), CW'(y), RW'(r)});
    endtask

    // drain the queue and the pipeline before touching registers
    task automatic drain;
        while (circle_q.size() > 0 || push_q.size() > 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic random_batch(int n, int span);
        int x, y;
        repeat (n) begin
            case ($urandom_range(3))
                0: add_circle($urandom, $urandom, $urandom);
                1: add_circle($signed(caps.start_x) + $urandom_range(2 * span) - span,
                              $signed(caps.start_y) + $urandom_range(2 * span) - span,
                              $urandom_range(span));
                default: begin
                    x = $signed(caps.end_x) + $urandom_range(2 * span) - span;
                    y = $signed(caps.end_y) + $urandom_range(2 * span) - span;
                    add_circle(x, y, $urandom_range(span));
                end
            endcase
        end
    endtask

    initial begin
        caps = '{start_x: '0, start_y: '0, end_x: '0, end_y: '0,
                 dir_x: 16'd16384, dir_y: '0, len: '0, rad: '0};
        idle_pct = 15;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset capsule is a point at the origin
        add_circle(0, 0, 0);
        add_circle(0, 0, 256);
        add_circle(100, 0, 300);
        add_circle(-300, 400, 600);
        add_circle(8388607, 8388607, 8388607);
        add_circle(-8388608, -8388608, 8388607);
        drain();

        set_capsule(-2560, 1280, 16384, 0, 5120, 512);
        add_circle(-2560, 1280, 100);           // on start point
        add_circle(2560, 1280, 100);            // on end point
        add_circle(0, 1280, 100);               // on the axis
        add_circle(0, 1500, 300);               // above the axis
        add_circle(0, 1000, 300);               // below the axis
        add_circle(-3000, 1500, 400);           // start cap
        add_circle(3000, 1100, 400);            // end cap
        add_circle(0, 4000, 10);                // clear of the capsule
        add_circle(-8388608, 8388607, 8388607); // saturating push
        add_circle(0, 8388607, 8388607);
        random_batch(350, 4000);
        drain();

        idle_pct = 69;
        set_capsule(1000, -2000, 11585, 11585, 10000, 0);
        random_batch(400, 15000);
        drain();

        idle_pct = 0;
        set_capsule(-8388608, 8388607, -16384, 0, 8388607, 8388607);
        write_reg(CFG_DIR_Y, CW'(-16384));
        random_batch(200, 100000);
        drain();
        set_capsule(0, 0, 0, -16384, 3000, 2000);
        random_batch(250, 6000);
        drain();

        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
